@@ hdl/wse_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wse_pkg: shared types and constants of the window statistics engine
// Field widths, result limits and the codes of the serial arithmetic unit.
// ----------------------------------------------------------------------------
package wse_pkg;

  localparam int WINDOW_DEPTH_DEF = 1024;

  localparam int SAMPLE_W = 16;
  localparam int MEAN_W   = 32;
  localparam int SD_W     = 32;
  localparam int SKEW_W   = 23;
  localparam int KURT_W   = 27;
  localparam int RATE_W   = 16;
  localparam int FRAC_W   = 16;

  // packed result fields: 162 bits, padded to whole bytes
  localparam int OUT_FIELDS_W = 2 * SAMPLE_W + MEAN_W + SD_W + SKEW_W + KURT_W + RATE_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  // integer square root unit: radicand and root widths
  localparam int SQ_W  = 32;
  localparam int RAD_W = 2 * SQ_W;

  // quotient limits before the roots
  localparam int SD_Q   = RAD_W;
  localparam int SKEW_Q = 2 * SKEW_W;

  localparam logic [SKEW_W-1:0] SKEW_POS_MAX = SKEW_W'(4194303);
  localparam logic [SKEW_W-1:0] SKEW_NEG_MAG = SKEW_W'(4194304);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sd32768;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sd32767;

  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } alu_ctl_t;

endpackage
`default_nettype wire

@@ hdl/wse_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wse_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module wse_ram #(
  parameter int W = 16,
  parameter int D = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ hdl/wse_moment.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wse_moment: central moment accumulator
// Raises one deviation magnitude to powers 2..4 chunk by chunk on one
// multiplier and adds the powers into the moment sums.
// ----------------------------------------------------------------------------
module wse_moment
  import wse_pkg::*;
#(
  parameter int MW = 30,
  parameter int CW = 11
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic                  clr,
  input  wire logic [MW-1:0]         mag,
  input  wire logic                  neg,
  output logic                       busy,
  output logic                       done,
  output logic [2*MW+CW-1:0]         m2,
  output logic [3*MW+CW-1:0]         m3p,
  output logic [3*MW+CW-1:0]         m3n,
  output logic [4*MW+CW-1:0]         m4
);

  localparam int PW  = 4 * MW;
  localparam int M2W = 2 * MW + CW;
  localparam int M3W = 3 * MW + CW;
  localparam int M4W = 4 * MW + CW;

  logic            run_r, phase_r, done_r, neg_r;
  logic [1:0]      pw_r, k_r;
  logic [PW-1:0]   p_r, acc_r;
  logic [2*MW-1:0] prod_r;
  logic [MW-1:0]   mag_r;
  logic [M2W-1:0]  m2_r;
  logic [M3W-1:0]  m3p_r, m3n_r;
  logic [M4W-1:0]  m4_r;

  logic [MW-1:0]   chunk;
  logic [PW-1:0]   shifted, sum_new;

  always_comb begin
    chunk   = p_r[k_r*MW +: MW];
    shifted = PW'(prod_r) << (k_r * MW);
    sum_new = acc_r + shifted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      phase_r <= 1'b0;
      done_r  <= 1'b0;
      m2_r    <= '0;
      m3p_r   <= '0;
      m3n_r   <= '0;
      m4_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (clr) begin
        m2_r  <= '0;
        m3p_r <= '0;
        m3n_r <= '0;
        m4_r  <= '0;
      end
      if (start && !run_r) begin
        run_r   <= 1'b1;
        phase_r <= 1'b0;
        pw_r    <= 2'd1;
        k_r     <= 2'd0;
        p_r     <= PW'(mag);
        acc_r   <= '0;
        mag_r   <= mag;
        neg_r   <= neg;
      end else if (run_r) begin
        if (!phase_r) begin
          prod_r  <= chunk * mag_r;
          phase_r <= 1'b1;
        end else begin
          phase_r <= 1'b0;
          if (k_r == pw_r - 2'd1) begin
            // power complete: it becomes the multiplicand of the next one
            p_r   <= sum_new;
            acc_r <= '0;
            k_r   <= 2'd0;
            pw_r  <= pw_r + 2'd1;
            case (pw_r)
              2'd1: m2_r <= m2_r + M2W'(sum_new[2*MW-1:0]);
              2'd2: begin
                if (neg_r) begin
                  m3n_r <= m3n_r + M3W'(sum_new[3*MW-1:0]);
                end else begin
                  m3p_r <= m3p_r + M3W'(sum_new[3*MW-1:0]);
                end
              end
              default: begin
                m4_r   <= m4_r + M4W'(sum_new);
                run_r  <= 1'b0;
                done_r <= 1'b1;
              end
            endcase
          end else begin
            acc_r <= sum_new;
            k_r   <= k_r + 2'd1;
          end
        end
      end
    end
  end

  assign busy = run_r;
  assign done = done_r;
  assign m2   = m2_r;
  assign m3p  = m3p_r;
  assign m3n  = m3n_r;
  assign m4   = m4_r;

endmodule
`default_nettype wire

@@ hdl/wse_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wse_alu: serial wide arithmetic unit
// Shift-add multiply, restoring divide and bitwise integer square root,
// one step per cycle on BW-bit operands; the root takes a RAD_W-bit radicand.
// ----------------------------------------------------------------------------
module wse_alu
  import wse_pkg::*;
#(
  parameter int BW = 256
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire alu_ctl_t      ctl,
  input  wire logic [BW-1:0] a,
  input  wire logic [BW-1:0] b,
  output logic               done,
  output logic [BW-1:0]      res
);

  localparam int NW = $clog2(BW);

  logic          run_r, done_r;
  logic [1:0]    op_r;
  logic [BW:0]   acc_r;
  logic [BW-1:0] x_r, y_r;
  logic [NW-1:0] cnt_r;

  logic [BW:0]      rem_sh;
  logic             ge;
  logic [SQ_W-1:0]  cand;
  logic [RAD_W-1:0] cand_sq;

  always_comb begin
    rem_sh  = {acc_r[BW-1:0], x_r[BW-1]};
    ge      = rem_sh >= {1'b0, y_r};
    cand    = y_r[SQ_W-1:0] | (SQ_W'(1) << (SQ_W - 1 - int'(cnt_r)));
    cand_sq = RAD_W'(cand) * RAD_W'(cand);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      op_r   <= OP_MUL;
    end else begin
      done_r <= 1'b0;
      if (ctl.start && !run_r) begin
        run_r <= 1'b1;
        op_r  <= ctl.op;
        acc_r <= '0;
        cnt_r <= '0;
        x_r   <= a;
        y_r   <= (ctl.op == OP_SQRT) ? '0 : b;
      end else if (run_r) begin
        cnt_r <= cnt_r + NW'(1);
        unique case (op_r)
          OP_MUL: begin
            if (y_r[0]) begin
              acc_r <= acc_r + (BW+1)'(x_r);
            end
            x_r <= x_r << 1;
            y_r <= y_r >> 1;
            if (y_r[BW-1:1] == '0) begin
              run_r  <= 1'b0;
              done_r <= 1'b1;
            end
          end
          OP_DIV: begin
            acc_r <= ge ? rem_sh - {1'b0, y_r} : rem_sh;
            x_r   <= {x_r[BW-2:0], ge};
            if (cnt_r == NW'(BW - 1)) begin
              run_r  <= 1'b0;
              done_r <= 1'b1;
            end
          end
          default: begin
            if (cand_sq <= x_r[RAD_W-1:0]) begin
              y_r <= BW'(cand);
            end
            if (cnt_r == NW'(SQ_W - 1)) begin
              run_r  <= 1'b0;
              done_r <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  assign done = done_r;
  always_comb begin
    unique case (op_r)
      OP_MUL:  res = acc_r[BW-1:0];
      OP_DIV:  res = x_r;
      default: res = y_r;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/window_statistics_engine_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// window_statistics_engine_top: statistics over a window of samples
// Max, min, mean, standard deviation, skewness, kurtosis, crossing rate.
// ----------------------------------------------------------------------------
// Usage:
//   Send signed 16-bit samples on in_tdata; in_tlast closes the window.
//   Samples load at one per cycle into the sample RAM while max, min, sum
//   and zero crossings are tracked. Samples beyond WINDOW_DEPTH are dropped,
//   but their tlast still closes the window.
//   After the last sample the block stops taking requests and makes a
//   second pass over the RAM: for each sample a RAM read, one deviation,
//   then powers 2..4 on the shared moment multiplier. It then runs a
//   sequence on the serial wide ALU: five divisions, several shift-add
//   multiplies and two roots; a degenerate window ends after the
//   crossing-rate division.
//   One result request comes out per window; degenerate (tuser) flags a
//   one-sample or zero-variance window, with moments forced to zero.
//   The result sits in an output register: a stalled receiver does not
//   block loading of the next window, only the hand-off of its result.
//   Reset (rst_n low, synchronous) clears all window state; the sample RAM
//   is not cleared, as only written entries are ever read.
// ----------------------------------------------------------------------------
module window_statistics_engine_top
  import wse_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [SAMPLE_W-1:0]   in_tdata,   // [15:0] sample
  input  wire logic                  in_tlast,   // last sample of the window
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [15:0] max_value, [31:16] min_value, [63:32] mean_value, [95:64] std_dev,
  // [118:96] skewness, [145:119] kurtosis, [161:146] crossing_rate, rest zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tuser   // [0] degenerate
);

  localparam int CW   = $clog2(WINDOW_DEPTH + 1);
  localparam int AW   = $clog2(WINDOW_DEPTH);
  localparam int SUMW = SAMPLE_W + CW;
  localparam int MW   = SAMPLE_W + CW + 1;
  localparam int M2W  = 2 * MW + CW;
  localparam int M3W  = 3 * MW + CW;
  localparam int M4W  = 4 * MW + CW;
  localparam int BW   = 6 * MW + 3 * CW + 32;

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_RD    = 3'd1;
  localparam logic [2:0] ST_EVAL  = 3'd2;
  localparam logic [2:0] ST_MWAIT = 3'd3;
  localparam logic [2:0] ST_CALC  = 3'd4;
  localparam logic [2:0] ST_CWAIT = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  // final arithmetic sequence
  localparam logic [3:0] STP_MEAN  = 4'd0;
  localparam logic [3:0] STP_RATE  = 4'd1;
  localparam logic [3:0] STP_NN    = 4'd2;
  localparam logic [3:0] STP_SCL   = 4'd3;
  localparam logic [3:0] STP_SDDIV = 4'd4;
  localparam logic [3:0] STP_SDSQ  = 4'd5;
  localparam logic [3:0] STP_M2SQ  = 4'd6;
  localparam logic [3:0] STP_M2CU  = 4'd7;
  localparam logic [3:0] STP_M3SQ  = 4'd8;
  localparam logic [3:0] STP_BND3  = 4'd9;
  localparam logic [3:0] STP_SKDIV = 4'd10;
  localparam logic [3:0] STP_SKSQ  = 4'd11;
  localparam logic [3:0] STP_BND4  = 4'd12;
  localparam logic [3:0] STP_KDIV  = 4'd13;

  logic [2:0] state_r;
  logic [3:0] step_r;

  logic [CW-1:0]                cnt_r, cc_r, idx_r;
  logic signed [SUMW-1:0]       sum_r;
  logic signed [SAMPLE_W-1:0]   max_r, min_r, prev_r;
  logic                         skip_r;

  logic signed [MEAN_W-1:0]     mean_r;
  logic [SD_W-1:0]              sd_r;
  logic [SKEW_W-1:0]            skew_r;
  logic [KURT_W-1:0]            kurt_r;
  logic [RATE_W-1:0]            rate_r;
  logic [BW-1:0]                tmp_r, scale_r, t1_r;

  logic                         out_valid_r, out_user_r;
  logic [OUT_DATA_W-1:0]        out_data_r;

  // ---- load side --------------------------------------------------------
  logic                         in_acc, store_ok;
  logic signed [SAMPLE_W-1:0]   x_s;

  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign x_s       = $signed(in_tdata);
  assign store_ok  = (cnt_r < CW'(WINDOW_DEPTH));

  // ---- sample RAM -------------------------------------------------------
  logic [SAMPLE_W-1:0] rd_data;

  wse_ram #(.W(SAMPLE_W), .D(WINDOW_DEPTH)) u_ram (
    .clk   (clk),
    .we    (in_acc && store_ok),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_tdata),
    .raddr (idx_r[AW-1:0]),
    .rdata (rd_data)
  );

  // ---- deviation: e = n*x - S ---------------------------------------------
  logic signed [MW-1:0] nx_w, e_w;
  logic [MW-1:0]        mag_w;

  always_comb begin
    nx_w  = MW'($signed({1'b0, cnt_r})) * MW'($signed(rd_data));
    e_w   = nx_w - MW'(sum_r);
    mag_w = e_w[MW-1] ? MW'(-e_w) : MW'(e_w);
  end

  logic           mom_busy, mom_done, mom_clr;
  logic [M2W-1:0] m2;
  logic [M3W-1:0] m3p, m3n;
  logic [M4W-1:0] m4;

  assign mom_clr = in_acc && in_tlast;

  wse_moment #(.MW(MW), .CW(CW)) u_moment (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_EVAL),
    .clr   (mom_clr),
    .mag   (mag_w),
    .neg   (e_w[MW-1]),
    .busy  (mom_busy),
    .done  (mom_done),
    .m2    (m2),
    .m3p   (m3p),
    .m3n   (m3n),
    .m4    (m4)
  );

  // ---- final arithmetic ---------------------------------------------------
  alu_ctl_t        alu_ctl;
  logic [BW-1:0]   alu_a, alu_b, alu_res;
  logic            alu_done;
  logic            sum_neg, m3_neg, degen;
  logic [SUMW-1:0] sum_mag;
  logic [M3W-1:0]  m3_mag;

  function automatic logic [BW-1:0] sat_to(input logic [BW-1:0] v, input int q);
    logic [BW-1:0] lim;
    lim = (BW'(1) << q) - BW'(1);
    return (v > lim) ? lim : v;
  endfunction

  always_comb begin
    sum_neg = sum_r[SUMW-1];
    sum_mag = sum_neg ? SUMW'(-sum_r) : SUMW'(sum_r);
    m3_neg  = m3n > m3p;
    m3_mag  = m3_neg ? m3n - m3p : m3p - m3n;
    degen   = (cnt_r == CW'(1)) || (m2 == '0);
  end

  always_comb begin
    alu_ctl.start = (state_r == ST_CALC);
    alu_ctl.op    = OP_MUL;
    alu_a         = tmp_r;
    alu_b         = scale_r;
    unique case (step_r)
      STP_MEAN: begin
        alu_ctl.op = OP_DIV;
        alu_a      = BW'(sum_mag) << FRAC_W;
        alu_b      = BW'(cnt_r);
      end
      STP_RATE: begin
        alu_ctl.op = OP_DIV;
        alu_a      = BW'(cc_r) << FRAC_W;
        alu_b      = BW'(cnt_r);
      end
      STP_NN: begin
        alu_a = BW'(cnt_r);
        alu_b = BW'(cnt_r);
      end
      STP_SCL: alu_b = BW'(cnt_r - CW'(1));
      STP_SDDIV: begin
        alu_ctl.op = OP_DIV;
        alu_a      = BW'(m2) << 32;
      end
      STP_SDSQ: begin
        alu_ctl.op = OP_SQRT;
        alu_a      = sat_to(tmp_r, SD_Q);
      end
      STP_M2SQ: begin
        alu_a = BW'(m2);
        alu_b = BW'(m2);
      end
      STP_M2CU: begin
        alu_a = t1_r;
        alu_b = BW'(m2);
      end
      STP_M3SQ: begin
        alu_a = BW'(m3_mag);
        alu_b = BW'(m3_mag);
      end
      STP_BND3: alu_b = BW'(cnt_r) << 32;
      STP_SKDIV: alu_ctl.op = OP_DIV;
      STP_SKSQ: begin
        alu_ctl.op = OP_SQRT;
        alu_a      = sat_to(tmp_r, SKEW_Q);
      end
      STP_BND4: begin
        alu_a = BW'(m4);
        alu_b = BW'(cnt_r) << FRAC_W;
      end
      STP_KDIV: begin
        alu_ctl.op = OP_DIV;
        alu_b      = t1_r;
      end
      default: ;
    endcase
  end

  wse_alu #(.BW(BW)) u_alu (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (alu_ctl),
    .a    (alu_a),
    .b    (alu_b),
    .done (alu_done),
    .res  (alu_res)
  );

  logic [SKEW_W-1:0] root_t;
  logic [BW-1:0]     kurt_sat;
  assign root_t   = alu_res[SKEW_W-1:0];
  assign kurt_sat = sat_to(alu_res, KURT_W);

  // ---- control ----------------------------------------------------------
  logic out_load;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      step_r      <= STP_MEAN;
      cnt_r       <= '0;
      cc_r        <= '0;
      idx_r       <= '0;
      sum_r       <= '0;
      max_r       <= SAMPLE_MIN;
      min_r       <= SAMPLE_MAX;
      prev_r      <= '0;
      skip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the held result once taken, unless a new one replaces it
      if (out_valid_r && out_tready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if (store_ok) begin
              sum_r  <= sum_r + SUMW'(x_s);
              prev_r <= x_s;
              cnt_r  <= cnt_r + CW'(1);
              if (x_s > max_r) max_r <= x_s;
              if (x_s < min_r) min_r <= x_s;
              // judge the pair (prev, x); a zero product skips the next pair
              if (cnt_r != '0) begin
                if (skip_r) begin
                  skip_r <= 1'b0;
                end else if (prev_r == '0 || x_s == '0) begin
                  cc_r   <= cc_r + CW'(1);
                  skip_r <= 1'b1;
                end else if (prev_r[SAMPLE_W-1] != x_s[SAMPLE_W-1]) begin
                  cc_r <= cc_r + CW'(1);
                end
              end
            end
            if (in_tlast) begin
              idx_r   <= '0;
              sd_r    <= '0;
              skew_r  <= '0;
              kurt_r  <= '0;
              state_r <= ST_RD;
            end
          end
        end
        ST_RD:   state_r <= ST_EVAL;
        ST_EVAL: state_r <= ST_MWAIT;
        ST_MWAIT: begin
          if (mom_done) begin
            idx_r <= idx_r + CW'(1);
            if (idx_r + CW'(1) == cnt_r) begin
              step_r  <= STP_MEAN;
              state_r <= ST_CALC;
            end else begin
              state_r <= ST_RD;
            end
          end
        end
        ST_CALC: state_r <= ST_CWAIT;
        ST_CWAIT: begin
          if (alu_done) begin
            case (step_r) inside
              STP_MEAN: mean_r <= sum_neg ? -$signed(alu_res[MEAN_W-1:0])
                                          : $signed(alu_res[MEAN_W-1:0]);
              STP_RATE: rate_r <= alu_res[RATE_W-1:0];
              STP_SDSQ: sd_r   <= alu_res[SD_W-1:0];
              STP_M2SQ: t1_r   <= alu_res;
              STP_SCL, STP_M2CU: scale_r <= alu_res;
              STP_SKSQ: begin
                if (m3_neg) begin
                  skew_r <= (root_t > SKEW_NEG_MAG) ? -SKEW_NEG_MAG : -root_t;
                end else begin
                  skew_r <= (root_t > SKEW_POS_MAX) ? SKEW_POS_MAX : root_t;
                end
              end
              STP_KDIV: kurt_r <= kurt_sat[KURT_W-1:0];
              default:  tmp_r  <= alu_res;
            endcase
            if ((step_r == STP_RATE && degen) || step_r == STP_KDIV) begin
              state_r <= ST_OUT;
            end else begin
              step_r  <= step_r + 4'd1;
              state_r <= ST_CALC;
            end
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_user_r  <= degen;
            out_data_r  <= {OUT_PAD_W'(0), rate_r, kurt_r, skew_r, sd_r,
                            mean_r, min_r, max_r};
            // clear the window for the next one
            cnt_r   <= '0;
            cc_r    <= '0;
            sum_r   <= '0;
            max_r   <= SAMPLE_MIN;
            min_r   <= SAMPLE_MAX;
            prev_r  <= '0;
            skip_r  <= 1'b0;
            state_r <= ST_LOAD;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // ---- assertions -------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(WINDOW_DEPTH))
    else $error("sample count beyond window depth");

  a_max_ge_min: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD && cnt_r != '0) |-> (max_r >= min_r))
    else $error("running max below running min");

  a_mom_idle_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> !mom_busy)
    else $error("moment unit busy while loading");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && degen |-> (sd_r == '0 && skew_r == '0 && kurt_r == '0))
    else $error("degenerate window with nonzero moments");

endmodule
`default_nettype wire

@@ tb/window_statistics_engine_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_statistics_engine_top_tb: self-checking bench for the statistics engine
// Sends windows of samples in random bursts, predicts each window's result with
// exact wide-integer arithmetic, and compares every result field by field.
// ----------------------------------------------------------------------------
module window_statistics_engine_top_tb;
  import wse_pkg::*;

  localparam int DEPTH      = WINDOW_DEPTH_DEF;
  localparam int CYCLE_CAP  = 10_000_000;
  localparam int ITEM_GOAL  = 1900;
  localparam int END_SETTLE = 50;

  // one queued input request; hold_for_drain makes the sender wait for all results
  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    logic                hold_for_drain;
  } sample_req_t;

  typedef struct {
    logic [OUT_DATA_W-1:0] data;
    logic                  degen;
  } window_stats_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [SAMPLE_W-1:0] in_tdata;     // [15:0] sample
  logic in_tlast;                    // last sample of the window
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // max, min, mean, sd, skew, kurt, rate, pad
  logic out_tuser;                   // [0] degenerate

  sample_req_t   sample_queue[$];
  window_stats_t stats_expected[$];

  // bench-side copy of the window state
  logic signed [SAMPLE_W-1:0] win_store[DEPTH];
  int                         win_count;
  longint                     win_sum;
  logic signed [SAMPLE_W-1:0] win_max, win_min, win_prev;
  logic                       win_skip;
  int                         win_cross;

  int  windows_accepted;
  int  results_done;
  int  mismatches;
  int  cycles = 0;
  int  burst_left, gap_left;
  int  ready_mode, ready_left;
  int  items_made;

  window_statistics_engine_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // largest t below 2^bits with t*t <= q
  function automatic logic [255:0] floor_root(input logic [255:0] q, input int bits);
    logic [255:0] t, c;
    t = '0;
    for (int b = bits - 1; b >= 0; b--) begin
      c = t | (256'd1 << b);
      if (c * c <= q) t = c;
    end
    return t;
  endfunction

  function automatic void clear_window_state();
    win_count = 0;
    win_sum   = 0;
    win_max   = SAMPLE_MIN;
    win_min   = SAMPLE_MAX;
    win_prev  = '0;
    win_skip  = 1'b0;
    win_cross = 0;
  endfunction

  // Fold one sample into the window; on last, close it and return its statistics.
  function automatic bit fold_sample(input logic [SAMPLE_W-1:0] raw, input logic last,
                                     output window_stats_t res);
    logic signed [SAMPLE_W-1:0] x;
    logic [255:0] m2, m3p, m3n, m4, mag, sq, m3, q;
    logic [255:0] sd, sk, ku;
    longint e, mean, n;
    logic signed [SKEW_W-1:0] skew;
    logic [RATE_W-1:0] rate;
    bit neg, degen;
    x = raw;
    res.data = '0;
    res.degen = 1'b0;
    if (win_count < DEPTH) begin
      win_store[win_count] = x;
      win_sum += x;
      if (x > win_max) win_max = x;
      if (x < win_min) win_min = x;
      if (win_count > 0) begin
        if (win_skip) begin
          win_skip = 1'b0;
        end else if ((win_prev < 0 && x > 0) || (win_prev > 0 && x < 0)) begin
          win_cross++;
        end else if (win_prev == 0 || x == 0) begin
          win_cross++;
          win_skip = 1'b1;
        end
      end
      win_prev = x;
      win_count++;
    end
    if (!last) return 0;

    n = win_count;
    m2 = '0; m3p = '0; m3n = '0; m4 = '0;
    for (int i = 0; i < win_count; i++) begin
      e   = n * longint'(win_store[i]) - win_sum;
      mag = 256'(e < 0 ? -e : e);
      sq  = mag * mag;
      m2 += sq;
      if (e < 0) m3n += sq * mag;
      else       m3p += sq * mag;
      m4 += sq * sq;
    end
    mean  = (win_sum * 65536) / n;
    rate  = RATE_W'((longint'(win_cross) << 16) / n);
    degen = (n == 1) || (m2 == 0);
    sd = '0;
    skew = '0;
    ku = '0;
    if (!degen) begin
      q  = (m2 << 32) / 256'(n * n * (n - 1));
      sd = floor_root(q, SD_W);
      neg = m3n > m3p;
      m3 = neg ? m3n - m3p : m3p - m3n;
      q  = ((m3 * m3 * 256'(n)) << 32) / (m2 * m2 * m2);
      sk = floor_root(q, SKEW_W);
      if (neg) skew = -SKEW_W'(sk > 4194304 ? 4194304 : sk);
      else     skew = SKEW_W'(sk > 4194303 ? 4194303 : sk);
      ku = ((m4 * 256'(n)) << 16) / (m2 * m2);
      if (ku > 134217727) ku = 134217727;
    end
    res.data[15:0]    = win_max;
    res.data[31:16]   = win_min;
    res.data[63:32]   = mean[31:0];
    res.data[95:64]   = sd[31:0];
    res.data[118:96]  = skew;
    res.data[145:119] = ku[26:0];
    res.data[161:146] = rate;
    res.degen         = degen;
    clear_window_state();
    return 1;
  endfunction

  function automatic void push_window(input int len, input int kind, input bit drain);
    sample_req_t r;
    logic [SAMPLE_W-1:0] level;
    level = SAMPLE_W'($urandom);
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: r.sample = SAMPLE_W'($urandom);
        1: r.sample = SAMPLE_W'($urandom_range(0, 6) - 3);       // near zero, many zeros
        2: r.sample = level;                                       // constant window
        3: r.sample = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
        default: r.sample = SAMPLE_W'($urandom_range(0, 2000) - 1000);
      endcase
      r.last = (i == len - 1);
      r.hold_for_drain = drain && (i == 0);
      sample_queue.insert(sample_queue.size(), r);
      items_made++;
    end
  endfunction

  function automatic void push_fixed(input logic [SAMPLE_W-1:0] s, input logic last);
    sample_req_t r;
    r.sample = s;
    r.last = last;
    r.hold_for_drain = 1'b0;
    sample_queue.insert(sample_queue.size(), r);
    items_made++;
  endfunction

  // Sender: bursts of random length with random gaps; hold on drain markers.
  always @(posedge clk) begin
    sample_req_t r;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      in_tlast   <= 1'b0;
      burst_left <= $urandom_range(1, 40);
      gap_left   <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (sample_queue.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (sample_queue[0].hold_for_drain &&
                   (windows_accepted != results_done ||
                    (in_tvalid && in_tlast))) begin
        in_tvalid <= 1'b0;  // wait until every result is back
      end else begin
        r = sample_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= r.sample;
        in_tlast  <= r.last;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: stall pattern switches between always-ready, coin-flip and mostly-stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_mode <= 0;
      ready_left <= 50;
    end else begin
      if (ready_left == 0) begin
        ready_mode <= $urandom_range(0, 2);
        ready_left <= $urandom_range(20, 400);
      end else begin
        ready_left <= ready_left - 1;
      end
      case (ready_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= $urandom_range(0, 1);
        default: out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Monitor: predict on every accepted sample, check every accepted result.
  always @(posedge clk) begin
    window_stats_t res, want;
    if (!rst_n) begin
      clear_window_state();
      windows_accepted <= 0;
      results_done     <= 0;
      mismatches       <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (fold_sample(in_tdata, in_tlast, res)) begin
          stats_expected.insert(stats_expected.size(), res);
          windows_accepted <= windows_accepted + 1;
        end
      end
      if (out_tvalid && out_tready) begin
        results_done <= results_done + 1;
        if (stats_expected.size() == 0) begin
          if (mismatches < 10) $display("unexpected result: data=%h degen=%b", out_tdata, out_tuser);
          mismatches <= mismatches + 1;
        end else begin
          want = stats_expected.pop_front();
          if (want.data !== out_tdata || want.degen !== out_tuser) begin
            if (mismatches < 10) begin
              $display("result %0d mismatch:", results_done);
              $display("  max      exp %h got %h", want.data[15:0], out_tdata[15:0]);
              $display("  min      exp %h got %h", want.data[31:16], out_tdata[31:16]);
              $display("  mean     exp %h got %h", want.data[63:32], out_tdata[63:32]);
              $display("  std_dev  exp %h got %h", want.data[95:64], out_tdata[95:64]);
              $display("  skewness exp %h got %h", want.data[118:96], out_tdata[118:96]);
              $display("  kurtosis exp %h got %h", want.data[145:119], out_tdata[145:119]);
              $display("  rate     exp %h got %h", want.data[161:146], out_tdata[161:146]);
              $display("  pad      exp %h got %h", want.data[OUT_DATA_W-1:162],
                       out_tdata[OUT_DATA_W-1:162]);
              $display("  degen    exp %b got %b", want.degen, out_tuser);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("window_statistics_engine_top regression: fail");
      $finish;
    end
  end

  initial begin
    int len, kind;
    items_made = 0;
    rst_n      = 1'b0;

    // directed: single-sample windows at both extremes
    push_fixed(SAMPLE_MAX, 1'b1);
    push_fixed(SAMPLE_MIN, 1'b1);
    // alternating extremes: every pair crosses, widest spread
    push_fixed(SAMPLE_MIN, 1'b0);
    push_fixed(SAMPLE_MAX, 1'b0);
    push_fixed(SAMPLE_MIN, 1'b0);
    push_fixed(SAMPLE_MAX, 1'b1);
    // zero product counts and skips the following pair
    push_fixed(16'sd5, 1'b0);
    push_fixed(16'sd0, 1'b0);
    push_fixed(-16'sd4, 1'b0);
    push_fixed(16'sd3, 1'b0);
    push_fixed(16'sd0, 1'b0);
    push_fixed(16'sd0, 1'b1);
    // zero variance
    push_fixed(-16'sd7, 1'b0);
    push_fixed(-16'sd7, 1'b0);
    push_fixed(-16'sd7, 1'b1);
    // skewed window with one outlier, negative mean
    push_fixed(-16'sd1, 1'b0);
    push_fixed(-16'sd1, 1'b0);
    push_fixed(-16'sd1, 1'b0);
    push_fixed(-16'sd1, 1'b0);
    push_fixed(SAMPLE_MIN, 1'b1);
    // overflowing window: samples past the store are dropped, last still closes
    push_window(DEPTH + 6, 0, 1'b1);
    push_window(3, 3, 1'b1);

    // random windows, mostly short; drain markers now and then
    while (items_made < ITEM_GOAL) begin
      len  = ($urandom_range(0, 29) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
      kind = $urandom_range(0, 9);
      if (kind > 4) kind = (kind > 7) ? 0 : 4;
      push_window(len, kind, $urandom_range(0, 24) == 0);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    wait (rst_n && sample_queue.size() == 0);
    @(posedge clk);
    while (in_tvalid || windows_accepted != results_done) @(posedge clk);
    repeat (END_SETTLE) @(posedge clk);

    if (mismatches == 0 && stats_expected.size() == 0) begin
      $display("window_statistics_engine_top regression: pass");
    end else begin
      $display("window_statistics_engine_top regression: fail");
    end
    $finish;
  end

endmodule
